### src/wlsq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wlsq_pkg;

   localparam int ACC_WIDTH = 48;
   localparam int IN_WIDTH = 24;
   localparam int DIFF_WIDTH = 25;
   localparam int PROD_WIDTH = 50;
   localparam int WIDE_WIDTH = 64;
   localparam int NORM_BITS = 22;
   localparam int OUT_WIDTH = 24;
   localparam int VCM_PER_VUM = 10000;

   typedef struct packed {
      logic                        is_center;
      logic signed [IN_WIDTH-1:0]  x_pos;
      logic signed [IN_WIDTH-1:0]  y_pos;
      logic signed [IN_WIDTH-1:0]  potential;
      logic                        last;
   } req_type;

   typedef struct packed {
      logic [OUT_WIDTH-1:0] field_magnitude;
      logic                 degenerate;
      logic                 saturated;
   } rsp_type;

   // Command to the shared divide / square-root unit.
   typedef struct packed {
      logic                    start;
      logic                    is_sqrt;
      logic [WIDE_WIDTH-1:0]   num;
      logic [WIDE_WIDTH-1:0]   den;
   } alu_cmd_type;

   typedef struct packed {
      logic                    done;
      logic [WIDE_WIDTH-1:0]   result;
   } alu_rsp_type;

endpackage
`default_nettype wire

### src/wlsq_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared unsigned unit: restoring divide (one quotient bit a cycle) or
// integer square root (one root bit a cycle), 64-bit operands.
module wlsq_alu
   import wlsq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire alu_cmd_type cmd,
   output      alu_rsp_type rsp
);

   localparam int CNT_WIDTH = $clog2(WIDE_WIDTH + 1);

   logic                  busy_ff, busy_in;
   logic                  sqrt_ff, sqrt_in;
   logic [CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic [WIDE_WIDTH-1:0] rem_ff, rem_in;
   logic [WIDE_WIDTH-1:0] quo_ff, quo_in;
   logic [WIDE_WIDTH-1:0] num_ff, num_in;
   logic [WIDE_WIDTH-1:0] den_ff, den_in;
   logic                  done_ff, done_in;

   logic [WIDE_WIDTH:0]   trial;
   logic [WIDE_WIDTH:0]   sub;
   logic [WIDE_WIDTH:0]   rt;

   always_comb begin
      busy_in = busy_ff;
      sqrt_in = sqrt_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      done_in = 1'b0;
      trial   = '0;
      sub     = '0;
      rt      = '0;
      if (cmd.start) begin
         busy_in = 1'b1;
         sqrt_in = cmd.is_sqrt;
         num_in  = cmd.num;
         den_in  = cmd.den;
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = cmd.is_sqrt ? CNT_WIDTH'(WIDE_WIDTH / 2) : CNT_WIDTH'(WIDE_WIDTH);
      end else if (busy_ff) begin
         if (sqrt_ff) begin
            // Bring down two bits; trial subtract 4*root+1.
            trial = {rem_ff[WIDE_WIDTH-3:0], num_ff[WIDE_WIDTH-1 -: 2], 1'b0};
            rt    = {quo_ff[WIDE_WIDTH-2:0], 2'b01};
            trial = trial >> 1;
            sub   = trial - rt;
            num_in = num_ff << 2;
            if (!sub[WIDE_WIDTH]) begin
               rem_in = sub[WIDE_WIDTH-1:0];
               quo_in = {quo_ff[WIDE_WIDTH-2:0], 1'b1};
            end else begin
               rem_in = trial[WIDE_WIDTH-1:0];
               quo_in = {quo_ff[WIDE_WIDTH-2:0], 1'b0};
            end
         end else begin
            trial  = {rem_ff, num_ff[WIDE_WIDTH-1]};
            sub    = trial - {1'b0, den_ff};
            num_in = num_ff << 1;
            if (!sub[WIDE_WIDTH]) begin
               rem_in = sub[WIDE_WIDTH-1:0];
               quo_in = {quo_ff[WIDE_WIDTH-2:0], 1'b1};
            end else begin
               rem_in = trial[WIDE_WIDTH-1:0];
               quo_in = {quo_ff[WIDE_WIDTH-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      sqrt_ff <= sqrt_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = quo_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("alu done while busy");
   a_cnt_zero: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> cnt_ff == '0 || $past(cmd.start) == 1'b0) else $error("alu count");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("alu done held");

endmodule
`default_nettype wire

### src/weighted_lsq_gradient_magnitude.sv
`timescale 1ns / 1ps
`default_nettype none
// Busy stays high until the word is done: a center word loads the center and clears the sums; a
// neighbor takes a root and five divided terms, or skips both when it sits on the center.
// A last word then adds a normalize and, unless the solve is degenerate, two divides and a
// root; a new word is taken only once the last one is done.
// The result strobes rsp_valid for one cycle as busy drops; the receiver cannot stall.
// Synchronous active-high reset clears the center and the five sums.
module weighted_lsq_gradient_magnitude
   import wlsq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output      logic    busy,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   output      rsp_type rsp_data
);

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_DIFF  = 5'd1;
   localparam logic [4:0] ST_SQ    = 5'd2;
   localparam logic [4:0] ST_ROOT  = 5'd3;
   localparam logic [4:0] ST_TERM  = 5'd4;
   localparam logic [4:0] ST_TDIV  = 5'd5;
   localparam logic [4:0] ST_ACC   = 5'd6;
   localparam logic [4:0] ST_CHK   = 5'd7;
   localparam logic [4:0] ST_MAX   = 5'd8;
   localparam logic [4:0] ST_SHIFT = 5'd9;
   localparam logic [4:0] ST_MUL   = 5'd10;
   localparam logic [4:0] ST_COMB  = 5'd11;
   localparam logic [4:0] ST_GDIV  = 5'd12;
   localparam logic [4:0] ST_GWAIT = 5'd13;
   localparam logic [4:0] ST_GSQ   = 5'd14;
   localparam logic [4:0] ST_MROOT = 5'd15;
   localparam logic [4:0] ST_OUT   = 5'd16;
   localparam logic [4:0] ST_GMUL  = 5'd17;

   localparam int COMP_WIDTH = 27;

   localparam logic signed [ACC_WIDTH-1:0] ACC_HI = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] ACC_LO = {1'b1, {(ACC_WIDTH-1){1'b0}}};
   localparam logic signed [WIDE_WIDTH-1:0] COMP_CLAMP = WIDE_WIDTH'(64'sd1 << 25);

   logic [4:0] state_ff, state_in;
   logic last_ff, last_in;
   logic signed [IN_WIDTH-1:0] cx_ff, cx_in, cy_ff, cy_in, cv_ff, cv_in;
   logic signed [IN_WIDTH-1:0] nx_ff, nx_in, ny_ff, ny_in, nv_ff, nv_in;
   logic signed [DIFF_WIDTH-1:0] dx_ff, dx_in, dy_ff, dy_in, dv_ff, dv_in;
   logic signed [ACC_WIDTH-1:0] sum_ff [5];
   logic signed [ACC_WIDTH-1:0] sum_in [5];
   logic [2:0] idx_ff, idx_in;
   logic [WIDE_WIDTH-1:0] dist_ff, dist_in;
   logic signed [WIDE_WIDTH-1:0] w_ff, w_in;      // general wide work register
   logic signed [WIDE_WIDTH-1:0] v_ff, v_in;
   logic tneg_ff, tneg_in;
   logic [5:0] sh_ff, sh_in;
   logic [WIDE_WIDTH-1:0] mx_ff, mx_in;
   logic signed [NORM_BITS:0] s5_ff [5];
   logic signed [NORM_BITS:0] s5_in [5];
   logic signed [WIDE_WIDTH-1:0] p_ff [6];
   logic signed [WIDE_WIDTH-1:0] p_in [6];
   logic signed [WIDE_WIDTH-1:0] det_ff, det_in, gnx_ff, gnx_in, gny_ff, gny_in;
   logic signed [WIDE_WIDTH-1:0] gx_ff, gx_in;
   logic gsel_ff, gsel_in;
   logic valid_ff, valid_in;
   rsp_type rsp_ff, rsp_in;
   alu_cmd_type cmd;
   alu_rsp_type arsp;

   logic signed [DIFF_WIDTH-1:0] pa, pb;
   logic signed [PROD_WIDTH-1:0] prod;
   logic signed [WIDE_WIDTH-1:0] quo_s, gclamp, acc_sum, sumw;
   logic [WIDE_WIDTH-1:0] mag_abs;
   logic signed [NORM_BITS:0] ma, mb;
   logic signed [2*NORM_BITS+1:0] mprod;
   logic signed [WIDE_WIDTH-1:0] gprod;
   logic signed [COMP_WIDTH-1:0] gxn, gyn;
   logic signed [2*COMP_WIDTH-1:0] gx_sq, gy_sq;

   wlsq_alu u_alu (.clock(clock), .reset(reset), .cmd(cmd), .rsp(arsp));

   function automatic logic [WIDE_WIDTH-1:0] absv(input logic signed [WIDE_WIDTH-1:0] v);
      absv = v[WIDE_WIDTH-1] ? WIDE_WIDTH'(-v) : WIDE_WIDTH'(v);
   endfunction

   always_comb begin
      unique case (idx_ff)
         3'd0:    begin pa = dx_ff; pb = dx_ff; end
         3'd1:    begin pa = dx_ff; pb = dy_ff; end
         3'd2:    begin pa = dy_ff; pb = dy_ff; end
         3'd3:    begin pa = dx_ff; pb = dv_ff; end
         default: begin pa = dy_ff; pb = dv_ff; end
      endcase
      prod = pa * pb;
      unique case (idx_ff)
         3'd0:    begin ma = s5_ff[0]; mb = s5_ff[2]; end
         3'd1:    begin ma = s5_ff[1]; mb = s5_ff[1]; end
         3'd2:    begin ma = s5_ff[3]; mb = s5_ff[2]; end
         3'd3:    begin ma = s5_ff[4]; mb = s5_ff[1]; end
         3'd4:    begin ma = s5_ff[0]; mb = s5_ff[4]; end
         default: begin ma = s5_ff[1]; mb = s5_ff[3]; end
      endcase
      mprod = ma * mb;
      gprod = (gsel_ff ? gny_ff : gnx_ff) * WIDE_WIDTH'(VCM_PER_VUM);
      // Both components are clamped to 2^25, so 27 bits hold them exactly.
      gxn = gx_ff[COMP_WIDTH-1:0];
      gyn = v_ff[COMP_WIDTH-1:0];
      gx_sq = gxn * gxn;
      gy_sq = gyn * gyn;
   end

   always_comb begin
      state_in = state_ff;
      last_in = last_ff;
      cx_in = cx_ff; cy_in = cy_ff; cv_in = cv_ff;
      nx_in = nx_ff; ny_in = ny_ff; nv_in = nv_ff;
      dx_in = dx_ff; dy_in = dy_ff; dv_in = dv_ff;
      sum_in = sum_ff;
      idx_in = idx_ff;
      dist_in = dist_ff;
      w_in = w_ff; v_in = v_ff;
      tneg_in = tneg_ff;
      sh_in = sh_ff; mx_in = mx_ff;
      s5_in = s5_ff; p_in = p_ff;
      det_in = det_ff; gnx_in = gnx_ff; gny_in = gny_ff;
      gx_in = gx_ff; gsel_in = gsel_ff;
      valid_in = 1'b0;
      rsp_in = rsp_ff;
      cmd = '0;
      quo_s = arsp.result[WIDE_WIDTH-1] ? '0 : WIDE_WIDTH'(arsp.result);
      quo_s = tneg_ff ? -quo_s : quo_s;
      gclamp = (quo_s > COMP_CLAMP) ? COMP_CLAMP :
               (quo_s < -COMP_CLAMP) ? -COMP_CLAMP : quo_s;
      sumw = WIDE_WIDTH'(sum_ff[idx_ff]);
      acc_sum = sumw + w_ff;
      mag_abs = absv(WIDE_WIDTH'(sum_ff[idx_ff]));
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               last_in = req_data.last;
               if (req_data.is_center) begin
                  cx_in = req_data.x_pos; cy_in = req_data.y_pos;
                  cv_in = req_data.potential;
                  for (int i = 0; i < 5; i++) sum_in[i] = '0;
                  state_in = ST_CHK;
               end else begin
                  nx_in = req_data.x_pos; ny_in = req_data.y_pos;
                  nv_in = req_data.potential;
                  state_in = ST_DIFF;
               end
            end
         end
         ST_DIFF: begin
            dx_in = DIFF_WIDTH'(nx_ff) - DIFF_WIDTH'(cx_ff);
            dy_in = DIFF_WIDTH'(ny_ff) - DIFF_WIDTH'(cy_ff);
            dv_in = DIFF_WIDTH'(nv_ff) - DIFF_WIDTH'(cv_ff);
            idx_in = 3'd0;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            // Products come from the same multiplier: dx*dx then dy*dy.
            if (idx_ff == 3'd0) begin
               w_in = WIDE_WIDTH'(prod);
               idx_in = 3'd2;
            end else begin
               w_in = w_ff + WIDE_WIDTH'(prod);
               if (w_ff == '0 && prod == '0) begin
                  state_in = ST_CHK;
               end else begin
                  cmd.start = 1'b1;
                  cmd.is_sqrt = 1'b1;
                  cmd.num = WIDE_WIDTH'(w_ff + WIDE_WIDTH'(prod));
                  state_in = ST_ROOT;
               end
            end
         end
         ST_ROOT: begin
            if (arsp.done) begin
               dist_in = arsp.result;
               idx_in = 3'd0;
               state_in = ST_TERM;
            end
         end
         ST_TERM: begin
            tneg_in = prod[PROD_WIDTH-1];
            cmd.start = 1'b1;
            cmd.num = absv(WIDE_WIDTH'(prod));
            cmd.den = dist_ff;
            state_in = ST_TDIV;
         end
         ST_TDIV: begin
            if (arsp.done) begin
               w_in = quo_s;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (acc_sum > WIDE_WIDTH'(ACC_HI)) sum_in[idx_ff] = ACC_HI;
            else if (acc_sum < WIDE_WIDTH'(ACC_LO)) sum_in[idx_ff] = ACC_LO;
            else sum_in[idx_ff] = acc_sum[ACC_WIDTH-1:0];
            if (idx_ff == 3'd4) begin
               state_in = ST_CHK;
            end else begin
               idx_in = idx_ff + 3'd1;
               state_in = ST_TERM;
            end
         end
         ST_CHK: begin
            if (last_ff) begin
               idx_in = 3'd0;
               mx_in = '0;
               state_in = ST_MAX;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MAX: begin
            if (mag_abs > mx_ff) mx_in = mag_abs;
            if (idx_ff == 3'd4) begin
               idx_in = 3'd0;
               sh_in = '0;
               state_in = ST_SHIFT;
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end
         ST_SHIFT: begin
            // One shift step per cycle until the largest sum fits.
            if ((mx_ff >> sh_ff) >= (WIDE_WIDTH'(1) << NORM_BITS)) begin
               sh_in = sh_ff + 6'd1;
            end else begin
               for (int i = 0; i < 5; i++)
                  s5_in[i] = sum_ff[i][ACC_WIDTH-1] ?
                     -(NORM_BITS+1)'(absv(WIDE_WIDTH'(sum_ff[i])) >> sh_ff) :
                      (NORM_BITS+1)'(absv(WIDE_WIDTH'(sum_ff[i])) >> sh_ff);
               idx_in = 3'd0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            p_in[idx_ff] = WIDE_WIDTH'(mprod);
            if (idx_ff == 3'd5) state_in = ST_COMB;
            else idx_in = idx_ff + 3'd1;
         end
         ST_COMB: begin
            det_in = p_ff[0] - p_ff[1];
            gnx_in = p_ff[2] - p_ff[3];
            gny_in = p_ff[4] - p_ff[5];
            gsel_in = 1'b0;
            if (p_ff[0] == p_ff[1]) begin
               rsp_in.field_magnitude = '0;
               rsp_in.degenerate = 1'b1;
               rsp_in.saturated = 1'b0;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_GMUL;
            end
         end
         ST_GMUL: begin
            w_in = gprod;
            state_in = ST_GDIV;
         end
         ST_GDIV: begin
            tneg_in = w_ff[WIDE_WIDTH-1] ^ det_ff[WIDE_WIDTH-1];
            cmd.start = 1'b1;
            cmd.num = absv(w_ff);
            cmd.den = absv(det_ff);
            state_in = ST_GWAIT;
         end
         ST_GWAIT: begin
            if (arsp.done) begin
               if (!gsel_ff) begin
                  gx_in = gclamp;
                  gsel_in = 1'b1;
                  state_in = ST_GMUL;
               end else begin
                  v_in = gclamp;
                  state_in = ST_GSQ;
               end
            end
         end
         ST_GSQ: begin
            cmd.start = 1'b1;
            cmd.is_sqrt = 1'b1;
            cmd.num = WIDE_WIDTH'(gx_sq) + WIDE_WIDTH'(gy_sq);
            state_in = ST_MROOT;
         end
         ST_MROOT: begin
            if (arsp.done) begin
               dist_in = arsp.result;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_in.degenerate = 1'b0;
            if (dist_ff > WIDE_WIDTH'({OUT_WIDTH{1'b1}})) begin
               rsp_in.field_magnitude = '1;
               rsp_in.saturated = 1'b1;
            end else begin
               rsp_in.field_magnitude = dist_ff[OUT_WIDTH-1:0];
               rsp_in.saturated = 1'b0;
            end
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         cx_ff <= '0; cy_ff <= '0; cv_ff <= '0;
         for (int i = 0; i < 5; i++) sum_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         cx_ff <= cx_in; cy_ff <= cy_in; cv_ff <= cv_in;
         sum_ff <= sum_in;
      end
      last_ff <= last_in;
      nx_ff <= nx_in; ny_ff <= ny_in; nv_ff <= nv_in;
      dx_ff <= dx_in; dy_ff <= dy_in; dv_ff <= dv_in;
      idx_ff <= idx_in; dist_ff <= dist_in;
      w_ff <= w_in; v_ff <= v_in; tneg_ff <= tneg_in;
      sh_ff <= sh_in; mx_ff <= mx_in;
      s5_ff <= s5_in; p_ff <= p_in;
      det_ff <= det_in; gnx_ff <= gnx_in; gny_ff <= gny_in;
      gx_ff <= gx_in; gsel_ff <= gsel_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_data = rsp_ff;

   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |-> rsp_data.field_magnitude == '0)
      else $error("degenerate with nonzero magnitude");
   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |-> rsp_data.field_magnitude == '1)
      else $error("saturated without clamp");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_IDLE) else $error("result while busy");

endmodule
`default_nettype wire

### tb/weighted_lsq_gradient_magnitude_test.sv
`timescale 1ns / 1ps
`default_nettype none
module weighted_lsq_gradient_magnitude_test;
   import wlsq_pkg::*;

   localparam longint SUM_MAX = (64'sd1 <<< (ACC_WIDTH - 1)) - 1;
   localparam longint SUM_MIN = -SUM_MAX - 1;
   localparam longint COMP_LIMIT = 64'sd1 <<< 25;
   localparam longint CYCLE_LIMIT = 5000000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   weighted_lsq_gradient_magnitude DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   // Predictor state.
   longint  node_cx, node_cy, node_cv;
   longint  moments[5];
   req_type pending_words[$];
   rsp_type expected_gradients[$];
   int      fail_count = 0;
   longint  cycle_count = 0;
   int      gap_left;
   bit      feeding_done;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint add_clamped(longint a, longint t);
      if (t > 0 && a > SUM_MAX - t) return SUM_MAX;
      if (t < 0 && a < SUM_MIN - t) return SUM_MIN;
      return a + t;
   endfunction

   function automatic longint clamp_component(longint g);
      if (g > COMP_LIMIT) return COMP_LIMIT;
      if (g < -COMP_LIMIT) return -COMP_LIMIT;
      return g;
   endfunction

   function automatic rsp_type solve_gradient();
      longint          s[5];
      longint unsigned biggest, m;
      int              sh;
      longint          det, nx, ny, gx, gy;
      longint unsigned mag;
      rsp_type         r;
      biggest = 0;
      for (int i = 0; i < 5; i++) begin
         m = moments[i] < 0 ? -moments[i] : moments[i];
         if (m > biggest) biggest = m;
      end
      sh = 0;
      while ((biggest >> sh) >= (64'd1 << NORM_BITS)) sh++;
      for (int i = 0; i < 5; i++) begin
         m = moments[i] < 0 ? -moments[i] : moments[i];
         m = m >> sh;
         s[i] = moments[i] < 0 ? -longint'(m) : longint'(m);
      end
      det = s[0] * s[2] - s[1] * s[1];
      nx = s[3] * s[2] - s[4] * s[1];
      ny = s[0] * s[4] - s[1] * s[3];
      r = '0;
      if (det == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      gx = clamp_component((nx * VCM_PER_VUM) / det);
      gy = clamp_component((ny * VCM_PER_VUM) / det);
      mag = int_sqrt(longint'(gx * gx) + longint'(gy * gy));
      if (mag > 64'd16777215) begin
         r.field_magnitude = '1;
         r.saturated = 1'b1;
      end else begin
         r.field_magnitude = mag[OUT_WIDTH-1:0];
      end
      return r;
   endfunction

   task automatic predict_word(req_type w);
      longint dx, dy, dv, d;
      if (w.is_center) begin
         node_cx = w.x_pos;
         node_cy = w.y_pos;
         node_cv = w.potential;
         for (int i = 0; i < 5; i++) moments[i] = 0;
      end else begin
         dx = longint'(w.x_pos) - node_cx;
         dy = longint'(w.y_pos) - node_cy;
         dv = longint'(w.potential) - node_cv;
         if (dx != 0 || dy != 0) begin
            d = int_sqrt(dx * dx + dy * dy);
            moments[0] = add_clamped(moments[0], (dx * dx) / d);
            moments[1] = add_clamped(moments[1], (dx * dy) / d);
            moments[2] = add_clamped(moments[2], (dy * dy) / d);
            moments[3] = add_clamped(moments[3], (dx * dv) / d);
            moments[4] = add_clamped(moments[4], (dy * dv) / d);
         end
      end
      if (w.last) expected_gradients.insert(expected_gradients.size(), solve_gradient());
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return 0;
      if (roll < 90) return $urandom_range(1, 4);
      return $urandom_range(20, 300);
   endfunction

   function automatic req_type make_word(bit c, int x, int y, int v, bit l);
      req_type w;
      w.is_center = c;
      w.x_pos = IN_WIDTH'(x);
      w.y_pos = IN_WIDTH'(y);
      w.potential = IN_WIDTH'(v);
      w.last = l;
      return w;
   endfunction

   task automatic queue_word(req_type w);
      pending_words.insert(pending_words.size(), w);
   endtask

   // Random signed 24-bit value: full range or a small offset from base.
   function automatic int rand_coord(int base, bit wide);
      if (wide) return $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
      return base + $signed($urandom_range(0, 2000)) - 1000;
   endfunction

   initial begin
      int cx, cy, cv, n, mode;
      bit wide;
      // Directed words.
      queue_word(make_word(0, 65536, 0, 65536, 1));
      queue_word(make_word(1, 0, 0, 0, 1));
      queue_word(make_word(1, 100, 200, 300, 0));
      queue_word(make_word(0, 100, 200, 999, 1));
      queue_word(make_word(1, 0, 0, 0, 0));
      queue_word(make_word(0, 65536, 0, 65536, 0));
      queue_word(make_word(0, 0, 65536, 131072, 1));
      queue_word(make_word(0, 65536, 65536, 0, 1));
      queue_word(make_word(1, -8388608, -8388608, -8388608, 0));
      queue_word(make_word(0, 8388607, -8388608, 8388607, 0));
      queue_word(make_word(0, -8388608, 8388607, 8388607, 1));
      queue_word(make_word(1, 8388607, 8388607, 8388607, 0));
      queue_word(make_word(0, 8388606, 8388607, -8388608, 0));
      queue_word(make_word(0, 8388607, 8388606, 8388607, 1));
      queue_word(make_word(1, 0, 0, 0, 0));
      queue_word(make_word(0, 1, 0, 8388607, 0));
      queue_word(make_word(0, 0, 1, -8388608, 1));
      queue_word(make_word(1, 0, 0, 0, 0));
      queue_word(make_word(0, 65536, 65536, 10, 0));
      queue_word(make_word(0, 131072, 131072, 20, 1));
      // Random neighbor sets, mostly well formed.
      while (pending_words.size() < 970) begin
         mode = $urandom_range(0, 9);
         wide = ($urandom_range(0, 3) == 0);
         cx = rand_coord(0, 1);
         cy = rand_coord(0, 1);
         cv = rand_coord(0, 1);
         n = $urandom_range(0, 5);
         if (mode != 0) queue_word(make_word(1, cx, cy, cv, n == 0));
         for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 15) == 0)
               queue_word(make_word(0, cx, cy, rand_coord(cv, 1), k == n - 1));
            else
               queue_word(make_word(0, rand_coord(cx, wide), rand_coord(cy, wide),
                  rand_coord(cv, wide), (k == n - 1) || ($urandom_range(0, 19) == 0)));
         end
      end
   end

   // Driver.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_data <= '0;
         gap_left <= pick_gap();
      end else if (start && !busy) begin
         predict_word(req_data);
         if (pending_words.size() != 0 && gap_left == 0) begin
            req_data <= pending_words.pop_front();
            gap_left <= pick_gap();
         end else begin
            start <= 1'b0;
         end
      end else if (!start) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (pending_words.size() != 0) begin
            start <= 1'b1;
            req_data <= pending_words.pop_front();
            gap_left <= pick_gap();
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_gradients.size() == 0) begin
            $error("unexpected result word %h", rsp_data);
            fail_count++;
         end else begin
            want = expected_gradients.pop_front();
            if (rsp_data.field_magnitude !== want.field_magnitude) begin
               $error("field_magnitude: expected %0d, actual %0d",
                  want.field_magnitude, rsp_data.field_magnitude);
               fail_count++;
            end
            if (rsp_data.degenerate !== want.degenerate) begin
               $error("degenerate: expected %0d, actual %0d",
                  want.degenerate, rsp_data.degenerate);
               fail_count++;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $error("saturated: expected %0d, actual %0d",
                  want.saturated, rsp_data.saturated);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_words.size() != 0 || start || busy) @(posedge clock);
      while (expected_gradients.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (fail_count == 0 && expected_gradients.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

### files.f
src/wlsq_pkg.sv
src/wlsq_alu.sv
src/weighted_lsq_gradient_magnitude.sv
tb/weighted_lsq_gradient_magnitude_test.sv
